### rtl/sae_pkg.sv
// Shared types and constants for the suffix automaton engine.
package sae_pkg;

  typedef enum logic [1:0] {
    CMD_APPEND = 2'd0,
    CMD_QUERY  = 2'd1,
    CMD_MATCH  = 2'd2,
    CMD_CLEAR  = 2'd3
  } cmd_t;

  localparam int DEF_MAX_TEXT = 1024;
  localparam int EPOCH_W      = 8;

  localparam int CMD_W   = 2;
  localparam int BYTE_W  = 8;
  localparam int FPOS_W  = 10;
  localparam int LEN_W   = 11;
  localparam int NCNT_W  = 12;

  localparam logic [LEN_W-1:0] QLEN_SAT = 11'd2047;
  localparam logic [LEN_W-1:0] MIDX_SAT = 11'd1023;
  localparam logic [LEN_W-1:0] NO_END   = 11'h7FF;

endpackage

### rtl/suffix_automaton_engine.sv
// Suffix automaton engine: online automaton build, pattern query and match runs.
//
// Command interface: a transaction is taken when start is high and busy is low;
// exactly one result follows, on the out_ ports for one cycle with out_valid,
// and the receiver cannot stall it. One transaction is worked at a time.
// State lives in two RAMs with registered reads: the transition RAM
// (2*MAX_TEXT rows of 256 entries, each tagged with an epoch) and the node
// RAM (length, suffix link, first position). Clear bumps the epoch, so rows
// need no clearing; a new node's row reads as empty by tag mismatch.
// Each step reads a RAM and then checks the registered read data:
//   append : a read and a check per suffix-link step, a read of the
//            target node when an edge is found, then a node write that
//            answers; a clone adds the row copy, the clone and q node
//            writes and a read and check per link step on the redirect
//            walk. A refused append answers straight from idle.
//   query  : a read and a check, then a node read on a found last byte.
//   match  : a read and a check, again per suffix link followed on a mismatch.
//   clear  : bumps the epoch. When the epoch wraps (every 2**EPOCH_W clears)
//            and after reset, a sweep writes every transition entry, one per
//            cycle, with busy high.
// A full text store answers an append with status 1 and changes nothing.
module suffix_automaton_engine
  import sae_pkg::*;
#(
  parameter int MAX_TEXT = DEF_MAX_TEXT
) (
  input  logic                     clk,
  input  logic                     rst_n,
  input  logic                     start,
  output logic                     busy,
  input  logic [CMD_W-1:0]         in_cmd,
  input  logic [BYTE_W-1:0]        in_byte_value,
  input  logic                     in_last,
  output logic                     out_valid,
  output logic                     out_status,
  output logic                     out_found,
  output logic [FPOS_W-1:0]        out_first_pos,
  output logic [LEN_W-1:0]         out_match_len,
  output logic [LEN_W-1:0]         out_best_len,
  output logic signed [LEN_W-1:0]  out_best_end,
  output logic [LEN_W-1:0]         out_text_len,
  output logic [NCNT_W-1:0]        out_node_count
);

  // node index, node count, length and position widths
  localparam int NIW = $clog2(2 * MAX_TEXT);
  localparam int NCW = $clog2(2 * MAX_TEXT + 1);
  localparam int LW  = $clog2(MAX_TEXT + 1);
  localparam int PW  = $clog2(MAX_TEXT);
  localparam int AW  = NIW + BYTE_W;

  typedef struct packed {
    logic [EPOCH_W-1:0] ep;
    logic [NIW-1:0]     tgt;
  } tent_t;

  typedef struct packed {
    logic [LW-1:0]  len;
    logic           link_ok;   // 0: no suffix link (root)
    logic [NIW-1:0] link;
    logic [PW-1:0]  fpos;
  } node_t;

  typedef enum logic [19:0] {
    ST_IDLE    = 20'h00001,
    ST_SWEEP   = 20'h00002,
    ST_L1_RD   = 20'h00004,
    ST_L1_CHK  = 20'h00008,
    ST_L1_RDQ  = 20'h00010,
    ST_L1_CMPQ = 20'h00020,
    ST_CL_COPY = 20'h00040,
    ST_CL_WCL  = 20'h00080,
    ST_CL_WQ   = 20'h00100,
    ST_L2_RD   = 20'h00200,
    ST_L2_CHK  = 20'h00400,
    ST_AP_FIN  = 20'h00800,
    ST_Q_RD    = 20'h01000,
    ST_Q_CHK   = 20'h02000,
    ST_Q_RDN   = 20'h04000,
    ST_Q_FIN   = 20'h08000,
    ST_M_RD    = 20'h10000,
    ST_M_CHK   = 20'h20000,
    ST_M_FIN   = 20'h40000,
    ST_CLR     = 20'h80000
  } state_t;

  // ---------------------------------------------------------------- memories
  tent_t tmem [2**AW];
  node_t nmem [2**NIW];

  logic [AW-1:0]  t_raddr, t_waddr;
  logic           t_we;
  tent_t          t_wdata, t_rd_r;
  logic [NIW-1:0] n_raddr, n_waddr;
  logic           n_we;
  node_t          n_wdata, n_rd_r;

  always_ff @(posedge clk) begin
    if (t_we) begin
      tmem[t_waddr] <= t_wdata;
    end
    t_rd_r <= tmem[t_raddr];
  end

  always_ff @(posedge clk) begin
    if (n_we) begin
      nmem[n_waddr] <= n_wdata;
    end
    n_rd_r <= nmem[n_raddr];
  end

  // ---------------------------------------------------------------- state
  state_t             state_r, state_nxt;
  logic [NCW-1:0]     nodes_used_r, nodes_used_nxt;
  logic [NIW-1:0]     last_node_r, last_node_nxt;
  logic [LW-1:0]      text_cnt_r, text_cnt_nxt;
  logic [NIW-1:0]     q_node_r, q_node_nxt;
  logic [LEN_W-1:0]   q_len_r, q_len_nxt;
  logic               q_fail_r, q_fail_nxt;
  logic [NIW-1:0]     m_node_r, m_node_nxt;
  logic [LW-1:0]      m_len_r, m_len_nxt;
  logic [LW-1:0]      best_len_r, best_len_nxt;
  logic [LEN_W-1:0]   best_end_r, best_end_nxt;
  logic [LEN_W-1:0]   m_idx_r, m_idx_nxt;
  logic [EPOCH_W-1:0] epoch_r, epoch_nxt;
  logic [AW-1:0]      sweep_r, sweep_nxt;
  logic               sweep_reply_r, sweep_reply_nxt;

  // per-transaction working registers (no reset)
  logic [BYTE_W-1:0]  byte_r, byte_nxt;
  logic               last_r, last_nxt;
  logic [NIW-1:0]     p_r, p_nxt;
  logic [NIW-1:0]     cur_r, cur_nxt;
  logic [LW-1:0]      cur_len_r, cur_len_nxt;
  logic [NIW-1:0]     link_cur_r, link_cur_nxt;
  logic [NIW-1:0]     cl_r, cl_nxt;
  logic [NIW-1:0]     q_r, q_nxt;
  node_t              qrec_r, qrec_nxt;
  logic [LW-1:0]      len_p_r, len_p_nxt;
  logic [8:0]         cp_cnt_r, cp_cnt_nxt;
  logic               first_r, first_nxt;

  // result registers
  logic               out_valid_r, out_valid_nxt;
  logic               out_status_r, out_status_nxt;
  logic               out_found_r, out_found_nxt;
  logic [FPOS_W-1:0]  out_fpos_r, out_fpos_nxt;
  logic [LEN_W-1:0]   out_mlen_r, out_mlen_nxt;
  logic [LEN_W-1:0]   out_blen_r, out_blen_nxt;
  logic [LEN_W-1:0]   out_bend_r, out_bend_nxt;

  // an entry is a live edge only if tagged with the current epoch
  logic t_hit;
  assign t_hit = (t_rd_r.ep == epoch_r) && (t_rd_r.tgt != '0);

  node_t root_rec;
  assign root_rec = '{len: '0, link_ok: 1'b0, link: '0, fpos: '0};

  always_comb begin
    logic             qf;
    logic [NIW-1:0]   qn;
    logic [LW-1:0]    nb;
    logic [LEN_W-1:0] ne;

    qf = q_fail_r;
    qn = q_node_r;
    nb = best_len_r;
    ne = best_end_r;

    state_nxt       = state_r;
    nodes_used_nxt  = nodes_used_r;
    last_node_nxt   = last_node_r;
    text_cnt_nxt    = text_cnt_r;
    q_node_nxt      = q_node_r;
    q_len_nxt       = q_len_r;
    q_fail_nxt      = q_fail_r;
    m_node_nxt      = m_node_r;
    m_len_nxt       = m_len_r;
    best_len_nxt    = best_len_r;
    best_end_nxt    = best_end_r;
    m_idx_nxt       = m_idx_r;
    epoch_nxt       = epoch_r;
    sweep_nxt       = sweep_r;
    sweep_reply_nxt = sweep_reply_r;
    byte_nxt        = byte_r;
    last_nxt        = last_r;
    p_nxt           = p_r;
    cur_nxt         = cur_r;
    cur_len_nxt     = cur_len_r;
    link_cur_nxt    = link_cur_r;
    cl_nxt          = cl_r;
    q_nxt           = q_r;
    qrec_nxt        = qrec_r;
    len_p_nxt       = len_p_r;
    cp_cnt_nxt      = cp_cnt_r;
    first_nxt       = first_r;

    out_valid_nxt   = 1'b0;
    out_status_nxt  = 1'b0;
    out_found_nxt   = 1'b0;
    out_fpos_nxt    = '0;
    out_mlen_nxt    = '0;
    out_blen_nxt    = '0;
    out_bend_nxt    = NO_END;

    t_raddr = {p_r, byte_r};
    t_we    = 1'b0;
    t_waddr = {p_r, byte_r};
    t_wdata = '{ep: epoch_r, tgt: cur_r};
    n_raddr = p_r;
    n_we    = 1'b0;
    n_waddr = '0;
    n_wdata = root_rec;

    case (state_r)
      ST_IDLE: begin
        if (start) begin
          byte_nxt  = in_byte_value;
          last_nxt  = in_last;
          first_nxt = 1'b1;
          case (cmd_t'(in_cmd))
            CMD_APPEND: begin
              if (text_cnt_r == LW'(MAX_TEXT)) begin
                out_valid_nxt  = 1'b1;
                out_status_nxt = 1'b1;
              end else begin
                cur_nxt        = nodes_used_r[NIW-1:0];
                nodes_used_nxt = nodes_used_r + 1'b1;
                p_nxt          = last_node_r;
                link_cur_nxt   = '0;
                state_nxt      = ST_L1_RD;
              end
            end
            CMD_QUERY: state_nxt = ST_Q_RD;
            CMD_MATCH: begin
              p_nxt     = m_node_r;
              state_nxt = ST_M_RD;
            end
            default:   state_nxt = ST_CLR;
          endcase
        end
      end

      ST_SWEEP: begin
        t_we    = 1'b1;
        t_waddr = sweep_r;
        t_wdata = '{ep: epoch_r, tgt: '0};
        n_we    = 1'b1;
        n_waddr = '0;
        sweep_nxt = sweep_r + 1'b1;
        if (sweep_r == '1) begin
          out_valid_nxt = sweep_reply_r;
          state_nxt     = ST_IDLE;
        end
      end

      // first suffix-link walk: add edges to the new node
      ST_L1_RD: state_nxt = ST_L1_CHK;

      ST_L1_CHK: begin
        if (first_r) begin
          cur_len_nxt = n_rd_r.len + 1'b1;
          first_nxt   = 1'b0;
        end
        len_p_nxt = n_rd_r.len;
        if (!t_hit) begin
          t_we    = 1'b1;
          t_wdata = '{ep: epoch_r, tgt: cur_r};
          if (n_rd_r.link_ok) begin
            p_nxt     = n_rd_r.link;
            state_nxt = ST_L1_RD;
          end else begin
            state_nxt = ST_AP_FIN;
          end
        end else begin
          q_nxt     = t_rd_r.tgt;
          state_nxt = ST_L1_RDQ;
        end
      end

      ST_L1_RDQ: begin
        n_raddr   = q_r;
        state_nxt = ST_L1_CMPQ;
      end

      ST_L1_CMPQ: begin
        qrec_nxt = n_rd_r;
        if ((LW+1)'(len_p_r) + 1'b1 == (LW+1)'(n_rd_r.len)) begin
          link_cur_nxt = q_r;
          state_nxt    = ST_AP_FIN;
        end else begin
          cl_nxt         = nodes_used_r[NIW-1:0];
          nodes_used_nxt = nodes_used_r + 1'b1;
          cp_cnt_nxt     = '0;
          state_nxt      = ST_CL_COPY;
        end
      end

      // row copy q -> clone, one entry a cycle, each write takes the registered read data
      ST_CL_COPY: begin
        t_raddr = {q_r, cp_cnt_r[7:0]};
        if (cp_cnt_r != '0) begin
          t_we    = 1'b1;
          t_waddr = {cl_r, 8'(cp_cnt_r - 1'b1)};
          t_wdata = '{ep: epoch_r, tgt: (t_hit ? t_rd_r.tgt : '0)};
        end
        cp_cnt_nxt = cp_cnt_r + 1'b1;
        if (cp_cnt_r[8]) begin
          state_nxt = ST_CL_WCL;
        end
      end

      ST_CL_WCL: begin
        n_we      = 1'b1;
        n_waddr   = cl_r;
        n_wdata   = '{len: len_p_r + 1'b1, link_ok: qrec_r.link_ok,
                      link: qrec_r.link, fpos: qrec_r.fpos};
        state_nxt = ST_CL_WQ;
      end

      ST_CL_WQ: begin
        n_we      = 1'b1;
        n_waddr   = q_r;
        n_wdata   = '{len: qrec_r.len, link_ok: 1'b1, link: cl_r, fpos: qrec_r.fpos};
        link_cur_nxt = cl_r;
        state_nxt = ST_L2_RD;
      end

      // second walk: redirect edges to q onto the clone
      ST_L2_RD: state_nxt = ST_L2_CHK;

      ST_L2_CHK: begin
        if (t_hit && (t_rd_r.tgt == q_r)) begin
          t_we    = 1'b1;
          t_wdata = '{ep: epoch_r, tgt: cl_r};
          if (n_rd_r.link_ok) begin
            p_nxt     = n_rd_r.link;
            state_nxt = ST_L2_RD;
          end else begin
            state_nxt = ST_AP_FIN;
          end
        end else begin
          state_nxt = ST_AP_FIN;
        end
      end

      ST_AP_FIN: begin
        n_we          = 1'b1;
        n_waddr       = cur_r;
        n_wdata       = '{len: cur_len_r, link_ok: 1'b1, link: link_cur_r,
                          fpos: text_cnt_r[PW-1:0]};
        last_node_nxt = cur_r;
        text_cnt_nxt  = text_cnt_r + 1'b1;
        out_valid_nxt = 1'b1;
        state_nxt     = ST_IDLE;
      end

      ST_Q_RD: begin
        t_raddr   = {q_node_r, byte_r};
        state_nxt = ST_Q_CHK;
      end

      ST_Q_CHK: begin
        if (!q_fail_r) begin
          if (t_hit) qn = t_rd_r.tgt;
          else       qf = 1'b1;
        end
        q_node_nxt = qn;
        q_fail_nxt = qf;
        if (q_len_r < QLEN_SAT) q_len_nxt = q_len_r + 1'b1;
        if (last_r && !qf) begin
          state_nxt = ST_Q_RDN;
        end else begin
          out_valid_nxt = 1'b1;
          state_nxt     = ST_IDLE;
          if (last_r) begin
            q_node_nxt = '0;
            q_len_nxt  = '0;
            q_fail_nxt = 1'b0;
          end
        end
      end

      ST_Q_RDN: begin
        n_raddr   = q_node_r;
        state_nxt = ST_Q_FIN;
      end

      ST_Q_FIN: begin
        out_found_nxt = 1'b1;
        out_fpos_nxt  = FPOS_W'(n_rd_r.fpos) - FPOS_W'(q_len_r) + 1'b1;
        out_valid_nxt = 1'b1;
        q_node_nxt    = '0;
        q_len_nxt     = '0;
        q_fail_nxt    = 1'b0;
        state_nxt     = ST_IDLE;
      end

      ST_M_RD: state_nxt = ST_M_CHK;

      ST_M_CHK: begin
        first_nxt = 1'b0;
        if (t_hit) begin
          m_len_nxt  = first_r ? m_len_r + 1'b1 : n_rd_r.len + 1'b1;
          m_node_nxt = t_rd_r.tgt;
          state_nxt  = ST_M_FIN;
        end else if (n_rd_r.link_ok) begin
          p_nxt     = n_rd_r.link;
          state_nxt = ST_M_RD;
        end else begin
          m_node_nxt = '0;
          m_len_nxt  = '0;
          state_nxt  = ST_M_FIN;
        end
      end

      ST_M_FIN: begin
        if (m_len_r > best_len_r) begin
          nb = m_len_r;
          ne = m_idx_r;
        end
        out_mlen_nxt  = LEN_W'(m_len_r);
        out_blen_nxt  = LEN_W'(nb);
        out_bend_nxt  = ne;
        out_valid_nxt = 1'b1;
        state_nxt     = ST_IDLE;
        if (last_r) begin
          m_node_nxt   = '0;
          m_len_nxt    = '0;
          best_len_nxt = '0;
          best_end_nxt = NO_END;
          m_idx_nxt    = '0;
        end else begin
          best_len_nxt = nb;
          best_end_nxt = ne;
          if (m_idx_r < MIDX_SAT) m_idx_nxt = m_idx_r + 1'b1;
        end
      end

      ST_CLR: begin
        n_we           = 1'b1;
        n_waddr        = '0;
        epoch_nxt      = epoch_r + 1'b1;
        nodes_used_nxt = NCW'(1);
        last_node_nxt  = '0;
        text_cnt_nxt   = '0;
        q_node_nxt     = '0;
        q_len_nxt      = '0;
        q_fail_nxt     = 1'b0;
        m_node_nxt     = '0;
        m_len_nxt      = '0;
        best_len_nxt   = '0;
        best_end_nxt   = NO_END;
        m_idx_nxt      = '0;
        if (epoch_r == '1) begin
          // tags would alias old rows: rewrite the whole table first
          sweep_nxt       = '0;
          sweep_reply_nxt = 1'b1;
          state_nxt       = ST_SWEEP;
        end else begin
          out_valid_nxt = 1'b1;
          state_nxt     = ST_IDLE;
        end
      end

      default: state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r       <= ST_SWEEP;
      nodes_used_r  <= NCW'(1);
      last_node_r   <= '0;
      text_cnt_r    <= '0;
      q_node_r      <= '0;
      q_len_r       <= '0;
      q_fail_r      <= 1'b0;
      m_node_r      <= '0;
      m_len_r       <= '0;
      best_len_r    <= '0;
      best_end_r    <= NO_END;
      m_idx_r       <= '0;
      epoch_r       <= '0;
      sweep_r       <= '0;
      sweep_reply_r <= 1'b0;
      out_valid_r   <= 1'b0;
    end else begin
      state_r       <= state_nxt;
      nodes_used_r  <= nodes_used_nxt;
      last_node_r   <= last_node_nxt;
      text_cnt_r    <= text_cnt_nxt;
      q_node_r      <= q_node_nxt;
      q_len_r       <= q_len_nxt;
      q_fail_r      <= q_fail_nxt;
      m_node_r      <= m_node_nxt;
      m_len_r       <= m_len_nxt;
      best_len_r    <= best_len_nxt;
      best_end_r    <= best_end_nxt;
      m_idx_r       <= m_idx_nxt;
      epoch_r       <= epoch_nxt;
      sweep_r       <= sweep_nxt;
      sweep_reply_r <= sweep_reply_nxt;
      out_valid_r   <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    byte_r       <= byte_nxt;
    last_r       <= last_nxt;
    p_r          <= p_nxt;
    cur_r        <= cur_nxt;
    cur_len_r    <= cur_len_nxt;
    link_cur_r   <= link_cur_nxt;
    cl_r         <= cl_nxt;
    q_r          <= q_nxt;
    qrec_r       <= qrec_nxt;
    len_p_r      <= len_p_nxt;
    cp_cnt_r     <= cp_cnt_nxt;
    first_r      <= first_nxt;
    out_status_r <= out_status_nxt;
    out_found_r  <= out_found_nxt;
    out_fpos_r   <= out_fpos_nxt;
    out_mlen_r   <= out_mlen_nxt;
    out_blen_r   <= out_blen_nxt;
    out_bend_r   <= out_bend_nxt;
  end

  // ---------------------------------------------------------------- ports
  assign busy           = (state_r != ST_IDLE);
  assign out_valid      = out_valid_r;
  assign out_status     = out_status_r;
  assign out_found      = out_found_r;
  assign out_first_pos  = out_fpos_r;
  assign out_match_len  = out_mlen_r;
  assign out_best_len   = out_blen_r;
  assign out_best_end   = out_bend_r;
  assign out_text_len   = LEN_W'(text_cnt_r);
  assign out_node_count = NCNT_W'(nodes_used_r);

  // ---------------------------------------------------------------- checks
  // a refused append answers straight from idle, so start counts as work too
  a_res_after_work: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> $past(busy || start))
    else $error("result without a transaction in flight");

  a_node_cap: assert property (@(posedge clk) disable iff (!rst_n)
    nodes_used_r <= NCW'(2 * MAX_TEXT))
    else $error("node count beyond capacity");

  a_text_cap: assert property (@(posedge clk) disable iff (!rst_n)
    text_cnt_r <= LW'(MAX_TEXT))
    else $error("text count beyond capacity");

  a_clone_distinct: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_CL_COPY) |-> (q_r != cl_r) && (cl_r != cur_r))
    else $error("clone aliases its source or the new node");

endmodule
